// ===== hdl/ubh_pkg.sv =====
// Shared types and constants of the equal-width histogram engine.
// Field widths, opcodes, register indexes and the divider status record.
// No dependencies.
`default_nettype none

package ubh_pkg;

    localparam int SAMPLE_W    = 32;   // signed Q16.16 sample and range_min
    localparam int WIDTH_W     = 31;   // unsigned Q15.16 bin_width
    localparam int BIN_COUNT_W = 11;   // bin_count register
    localparam int OPCODE_W    = 2;
    localparam int SEL_W       = 10;   // bin_select and bin_index
    localparam int TOTAL_W     = 32;   // bin_total
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 32;

    // Quotient bits worth resolving: bins in use never exceed 2^BIN_COUNT_W - 1.
    localparam int QUOT_W = BIN_COUNT_W;

    typedef enum logic [OPCODE_W-1:0] {
        OP_ADD        = 2'd0,
        OP_READ       = 2'd1,
        OP_READ_CLEAR = 2'd2
    } opcode_t;

    localparam logic [CFG_INDEX_W-1:0] CFG_RANGE_MIN = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_BIN_WIDTH = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_BIN_COUNT = 2'd2;

    localparam logic [SAMPLE_W-1:0]    RANGE_MIN_RST = 32'sd0;
    localparam logic [WIDTH_W-1:0]     BIN_WIDTH_RST = 31'd65536;
    localparam logic [BIN_COUNT_W-1:0] BIN_COUNT_RST = 11'd1024;

    typedef struct packed {
        logic              done;
        logic              out_of_range;
        logic [QUOT_W-1:0] quotient;
    } div_status_t;

endpackage

`default_nettype wire

// ===== hdl/ubh_in_if.sv =====
// Input channel of the histogram engine: valid/ready plus one item.
// Depends on ubh_pkg for field widths.
`default_nettype none

interface ubh_in_if;
    logic                              valid;
    logic                              ready;
    logic [ubh_pkg::OPCODE_W-1:0]      opcode;
    logic signed [ubh_pkg::SAMPLE_W-1:0] sample;
    logic [ubh_pkg::SEL_W-1:0]         bin_select;

    modport source (output valid, output opcode, output sample, output bin_select,
                    input ready);
    modport sink   (input valid, input opcode, input sample, input bin_select,
                    output ready);
endinterface

`default_nettype wire

// ===== hdl/ubh_out_if.sv =====
// Result channel of the histogram engine: valid/ready plus one result.
// Depends on ubh_pkg for field widths.
`default_nettype none

interface ubh_out_if;
    logic                         valid;
    logic                         ready;
    logic [ubh_pkg::SEL_W-1:0]    bin_index;
    logic                         in_range;
    logic [ubh_pkg::TOTAL_W-1:0]  bin_total;

    modport source (output valid, output bin_index, output in_range, output bin_total,
                    input ready);
    modport sink   (input valid, input bin_index, input in_range, input bin_total,
                    output ready);
endinterface

`default_nettype wire

// ===== hdl/ubh_bin_div.sv =====
// Radix-2 restoring divider that turns a sample offset into a bin number.
// Depends on ubh_pkg for widths and the div_status_t record.
`default_nettype none

module ubh_bin_div
(
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           start,
    input  wire logic                           dividend_neg,
    input  wire logic [ubh_pkg::SAMPLE_W-1:0]   dividend,
    input  wire logic [ubh_pkg::WIDTH_W-1:0]    divisor,
    output ubh_pkg::div_status_t                status
);

    localparam int STEPS   = ubh_pkg::QUOT_W + 1;
    localparam int CNT_W   = $clog2(STEPS);
    localparam int SHIFT_W = ubh_pkg::WIDTH_W + ubh_pkg::QUOT_W;

    logic                          run_reg;
    logic                          done_reg;
    logic                          neg_reg;
    logic [ubh_pkg::SAMPLE_W-1:0]  rem_reg;
    logic [SHIFT_W-1:0]            dsh_reg;
    logic [ubh_pkg::QUOT_W:0]      quot_reg;
    logic [CNT_W-1:0]              step_reg;
    logic                          ge;

    // The first step tests against divisor << QUOT_W: a set bit there means
    // the bin lies past anything bin_count can admit (a zero divisor lands here too).
    assign ge = SHIFT_W'(rem_reg) >= dsh_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else if (start)
        begin
            run_reg  <= 1'b1;
            done_reg <= 1'b0;
        end
        else if (run_reg)
        begin
            if (step_reg == '0)
            begin
                run_reg  <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            neg_reg  <= dividend_neg;
            rem_reg  <= dividend;
            dsh_reg  <= {divisor, {ubh_pkg::QUOT_W{1'b0}}};
            quot_reg <= '0;
            step_reg <= CNT_W'(STEPS - 1);
        end
        else if (run_reg)
        begin
            quot_reg <= {quot_reg[ubh_pkg::QUOT_W-1:0], ge};
            if (ge)
            begin
                rem_reg <= rem_reg - dsh_reg[ubh_pkg::SAMPLE_W-1:0];
            end
            dsh_reg  <= dsh_reg >> 1;
            step_reg <= step_reg - CNT_W'(1);
        end
    end

    assign status.done         = done_reg;
    assign status.out_of_range = neg_reg | quot_reg[ubh_pkg::QUOT_W];
    assign status.quotient     = quot_reg[ubh_pkg::QUOT_W-1:0];

endmodule

`default_nettype wire

// ===== hdl/ubh_count_ram.sv =====
// Simple dual-port counter memory: one write port, one registered read port.
// No package dependencies.
`default_nettype none

module ubh_count_ram
#(
    parameter int DEPTH  = 1024,
    parameter int ADDR_W = 10,
    parameter int DATA_W = 32
)
(
    input  wire logic              clk,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [DATA_W-1:0] wr_data,
    input  wire logic              rd_en,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output logic      [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// ===== hdl/uniform_bin_histogram.sv =====
// Equal-width histogram engine. An add beat places its Q16.16 sample into bin
// floor((sample - range_min) / bin_width) and bumps that bin's counter, which
// saturates; a read beat returns a counter, a read-and-clear beat returns it and
// zeroes it. Each input beat gives exactly one result beat. Items are handled
// one at a time: an add runs the 12-step radix-2 divider (one quotient bit per
// cycle) and, if the sample hits a bin, a read-modify-write of its counter in
// the counter memory, whose read port is registered; a read that hits reads its
// counter, and a read out of range or an unused opcode goes straight to a result.
// A finished result sits in an output register, so the next item is taken while
// it waits; a stalled result side lengthens an item only when a second result is
// ready behind it. After reset the block sweeps zeros into every counter memory
// entry and takes no item meanwhile; configuration writes are taken at any time,
// and must only be made while no item is in flight.
// Depends on ubh_pkg, ubh_in_if, ubh_out_if, ubh_bin_div and ubh_count_ram.
`default_nettype none

module uniform_bin_histogram
#(
    parameter int NUM_BINS    = 1024,
    parameter int COUNT_WIDTH = 32
)
(
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_wr_en,
    input  wire logic [ubh_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  wire logic [ubh_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    ubh_in_if.sink                                 req,
    ubh_out_if.source                              rsp
);

    localparam int          BIN_AW    = $clog2(NUM_BINS);
    localparam logic [31:0] BIN_LIMIT = 32'(NUM_BINS);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DIV,
        ST_READ,
        ST_MODIFY,
        ST_DONE
    } state_t;

    // Configuration registers.
    logic [ubh_pkg::SAMPLE_W-1:0]    range_min_reg;
    logic [ubh_pkg::WIDTH_W-1:0]     bin_width_reg;
    logic [ubh_pkg::BIN_COUNT_W-1:0] bin_count_reg;

    // Sequencer state and the item in flight.
    state_t                          state_reg;
    logic [BIN_AW-1:0]               clr_addr_reg;
    logic [ubh_pkg::OPCODE_W-1:0]    op_reg;
    logic [BIN_AW-1:0]               addr_reg;

    // Result being built, and the output register.
    logic [ubh_pkg::SEL_W-1:0]       res_index_reg;
    logic                            res_hit_reg;
    logic [ubh_pkg::TOTAL_W-1:0]     res_total_reg;
    logic                            out_valid_reg;
    logic [ubh_pkg::SEL_W-1:0]       out_index_reg;
    logic                            out_hit_reg;
    logic [ubh_pkg::TOTAL_W-1:0]     out_total_reg;

    logic                            accept;
    logic                            out_free;
    logic [ubh_pkg::SAMPLE_W:0]      diff;
    logic                            sel_in_use;
    logic                            quot_in_use;
    ubh_pkg::div_status_t            div_stat;

    logic                            mem_wr_en;
    logic [BIN_AW-1:0]               mem_wr_addr;
    logic [COUNT_WIDTH-1:0]          mem_wr_data;
    logic                            mem_rd_en;
    logic [COUNT_WIDTH-1:0]          mem_rd_data;
    logic [COUNT_WIDTH-1:0]          count_inc;

    // ------------------------------------------------------------------
    // Configuration port
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            range_min_reg <= ubh_pkg::RANGE_MIN_RST;
            bin_width_reg <= ubh_pkg::BIN_WIDTH_RST;
            bin_count_reg <= ubh_pkg::BIN_COUNT_RST;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                ubh_pkg::CFG_RANGE_MIN:
                    range_min_reg <= cfg_wdata[ubh_pkg::SAMPLE_W-1:0];
                ubh_pkg::CFG_BIN_WIDTH:
                    bin_width_reg <= cfg_wdata[ubh_pkg::WIDTH_W-1:0];
                ubh_pkg::CFG_BIN_COUNT:
                    bin_count_reg <= cfg_wdata[ubh_pkg::BIN_COUNT_W-1:0];
                default:
                    ;   // drop writes to unassigned indexes
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Input decode
    // ------------------------------------------------------------------
    assign req.ready = (state_reg == ST_IDLE);
    assign accept    = req.valid && req.ready;

    // Sign-extend both operands so the offset never wraps.
    assign diff = {req.sample[ubh_pkg::SAMPLE_W-1], req.sample}
                - {range_min_reg[ubh_pkg::SAMPLE_W-1], range_min_reg};

    // A bin is usable only below both bin_count and the built depth.
    assign sel_in_use = ({1'b0, req.bin_select} < bin_count_reg)
                     && (32'(req.bin_select) < BIN_LIMIT);

    assign quot_in_use = !div_stat.out_of_range
                      && (div_stat.quotient < bin_count_reg)
                      && (32'(div_stat.quotient) < BIN_LIMIT);

    ubh_bin_div u_div
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (accept && (req.opcode == ubh_pkg::OP_ADD)),
        .dividend_neg (diff[ubh_pkg::SAMPLE_W]),
        .dividend     (diff[ubh_pkg::SAMPLE_W-1:0]),
        .divisor      (bin_width_reg),
        .status       (div_stat)
    );

    // ------------------------------------------------------------------
    // Counter memory: clear sweep, then read-modify-write per item.
    // Only one item is in flight, so a write always lands before the next read.
    // ------------------------------------------------------------------
    assign count_inc = (mem_rd_data == '1) ? mem_rd_data
                                           : mem_rd_data + COUNT_WIDTH'(1);

    always_comb
    begin
        mem_rd_en   = (state_reg == ST_READ);
        mem_wr_en   = 1'b0;
        mem_wr_addr = addr_reg;
        mem_wr_data = '0;
        if (state_reg == ST_CLEAR)
        begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = clr_addr_reg;
        end
        else if (state_reg == ST_MODIFY)
        begin
            if (op_reg == ubh_pkg::OP_ADD)
            begin
                mem_wr_en   = 1'b1;
                mem_wr_data = count_inc;
            end
            else if (op_reg == ubh_pkg::OP_READ_CLEAR)
            begin
                mem_wr_en   = 1'b1;
            end
        end
    end

    ubh_count_ram
    #(
        .DEPTH  (NUM_BINS),
        .ADDR_W (BIN_AW),
        .DATA_W (COUNT_WIDTH)
    )
    u_ram
    (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_en   (mem_rd_en),
        .rd_addr (addr_reg),
        .rd_data (mem_rd_data)
    );

    // ------------------------------------------------------------------
    // Sequencer and output register
    // ------------------------------------------------------------------
    assign out_free = !out_valid_reg || rsp.ready;

    // Load on a finished item, drop once the held beat is taken.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if ((state_reg == ST_DONE) && out_free)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_addr_reg  <= '0;
        end
        else
        begin
            unique case (state_reg)
                ST_CLEAR:
                begin
                    clr_addr_reg <= clr_addr_reg + BIN_AW'(1);
                    if (clr_addr_reg == BIN_AW'(NUM_BINS - 1))
                    begin
                        state_reg <= ST_IDLE;
                    end
                end

                ST_IDLE:
                begin
                    if (accept)
                    begin
                        op_reg        <= req.opcode;
                        res_hit_reg   <= 1'b0;
                        res_total_reg <= '0;
                        case (req.opcode) inside
                            ubh_pkg::OP_ADD:
                            begin
                                res_index_reg <= '0;
                                state_reg     <= ST_DIV;
                            end
                            ubh_pkg::OP_READ, ubh_pkg::OP_READ_CLEAR:
                            begin
                                res_index_reg <= req.bin_select;
                                addr_reg      <= BIN_AW'(req.bin_select);
                                state_reg     <= sel_in_use ? ST_READ : ST_DONE;
                            end
                            default:
                            begin
                                res_index_reg <= '0;
                                state_reg     <= ST_DONE;
                            end
                        endcase
                    end
                end

                ST_DIV:
                begin
                    if (div_stat.done)
                    begin
                        if (quot_in_use)
                        begin
                            res_index_reg <= ubh_pkg::SEL_W'(div_stat.quotient);
                            addr_reg      <= BIN_AW'(div_stat.quotient);
                            state_reg     <= ST_READ;
                        end
                        else
                        begin
                            state_reg <= ST_DONE;
                        end
                    end
                end

                ST_READ:
                begin
                    state_reg <= ST_MODIFY;
                end

                ST_MODIFY:
                begin
                    res_hit_reg <= 1'b1;
                    if (op_reg == ubh_pkg::OP_ADD)
                    begin
                        res_total_reg <= ubh_pkg::TOTAL_W'(count_inc);
                    end
                    else
                    begin
                        res_total_reg <= ubh_pkg::TOTAL_W'(mem_rd_data);
                    end
                    state_reg <= ST_DONE;
                end

                ST_DONE:
                begin
                    // Hold until the output register is free or draining.
                    if (out_free)
                    begin
                        out_index_reg <= res_index_reg;
                        out_hit_reg   <= res_hit_reg;
                        out_total_reg <= res_total_reg;
                        state_reg     <= ST_IDLE;
                    end
                end

                default:
                    state_reg <= ST_IDLE;
            endcase
        end
    end

    assign rsp.valid     = out_valid_reg;
    assign rsp.bin_index = out_index_reg;
    assign rsp.in_range  = out_hit_reg;
    assign rsp.bin_total = out_total_reg;

endmodule

`default_nettype wire
